// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/upr_pkg.sv =====
// ----------------------------------------------------------------------------
// Undistortion package
// Shared types and codes of the radial-tangential undistortion block.
// ----------------------------------------------------------------------------
`default_nettype none
package upr_pkg;
   localparam int REG_K1  = 0;
   localparam int REG_K2  = 1;
   localparam int REG_K3  = 2;
   localparam int REG_P1  = 3;
   localparam int REG_P2  = 4;
   localparam int REG_TOL = 5;
   localparam int REG_LIM = 6;
   localparam int CSR_IDX_BITS = 3;
   localparam int TOL_BITS = 16;
   localparam int LIM_BITS = 8;

   localparam logic [1:0] OUT_CONVERGED = 2'd0;
   localparam logic [1:0] OUT_NEG_SCALE = 2'd1;
   localparam logic [1:0] OUT_LIMIT     = 2'd2;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_OP,
      ST_OPWAIT,
      ST_RECIP,
      ST_RECIPWAIT,
      ST_DECIDE,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/upr_alu.sv =====
// ----------------------------------------------------------------------------
// Undistortion arithmetic unit
// Shared saturating multiply (rounded, Q format) and add/subtract, with a
// two-stage multiply path.
// ----------------------------------------------------------------------------
`default_nettype none
module upr_alu #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 27
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  upr_pkg::alu_op_type          op,
   input  wire signed [COORD_BITS-1:0]  a,
   input  wire signed [COORD_BITS-1:0]  b,
   output logic                         done,
   output logic signed [COORD_BITS-1:0] res
);
   localparam int PW = 2 * COORD_BITS;
   localparam logic signed [COORD_BITS-1:0] VMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] VMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic              neg_ff, neg_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [1:0]        stage_ff, stage_in;
   logic signed [COORD_BITS-1:0] res_ff, res_in;
   logic [COORD_BITS-1:0] ma, mb;
   logic signed [COORD_BITS:0] sum;
   logic [PW:0]       rnd;
   logic [PW-FRAC_BITS:0] mq;

   always_comb begin
      ma = a[COORD_BITS-1] ? COORD_BITS'(-a) : COORD_BITS'(a);
      mb = b[COORD_BITS-1] ? COORD_BITS'(-b) : COORD_BITS'(b);
      neg_in = neg_ff;
      prod_in = prod_ff;
      stage_in = {stage_ff[0], 1'b0};
      res_in = res_ff;
      sum = '0;
      rnd = {1'b0, prod_ff} + (PW+1)'({1'b1, {(FRAC_BITS-1){1'b0}}});
      mq = rnd[PW:FRAC_BITS];
      if (start) begin
         case (op)
            upr_pkg::ALU_MUL: begin
               neg_in = a[COORD_BITS-1] ^ b[COORD_BITS-1];
               prod_in = PW'(ma) * PW'(mb);
               stage_in = 2'b01;
            end
            upr_pkg::ALU_ADD, upr_pkg::ALU_SUB: begin
               sum = (op == upr_pkg::ALU_ADD) ?
                     ({a[COORD_BITS-1], a} + {b[COORD_BITS-1], b}) :
                     ({a[COORD_BITS-1], a} - {b[COORD_BITS-1], b});
               if (sum[COORD_BITS] != sum[COORD_BITS-1])
                  res_in = sum[COORD_BITS] ? VMIN : VMAX;
               else
                  res_in = sum[COORD_BITS-1:0];
               stage_in = 2'b10;
            end
            default: stage_in = 2'b00;
         endcase
      end else if (stage_ff[0]) begin
         if (neg_ff) begin
            if (mq > (PW-FRAC_BITS+1)'({1'b1, {(COORD_BITS-1){1'b0}}}))
               res_in = VMIN;
            else
               res_in = COORD_BITS'(-mq);
         end else begin
            if (mq > (PW-FRAC_BITS+1)'(VMAX))
               res_in = VMAX;
            else
               res_in = COORD_BITS'(mq);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
   end

   assign done = stage_ff[1];
   assign res = res_ff;
endmodule
`default_nettype wire

// ===== rtl/upr_recip.sv =====
// ----------------------------------------------------------------------------
// Undistortion reciprocal unit
// Restoring divider: round(2^(2F) / d) for positive d, one bit a cycle,
// saturated to the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none
module upr_recip #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 27
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [COORD_BITS-1:0]        den,
   output logic                         done,
   output logic signed [COORD_BITS-1:0] quo
);
   `include "assert_macros.svh"
   localparam int NB = 2 * FRAC_BITS + 2;
   localparam int CW = $clog2(NB + 1);
   localparam int RW = COORD_BITS + 1;
   localparam logic [COORD_BITS-1:0] VMAX = {1'b0, {(COORD_BITS-1){1'b1}}};

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [NB-1:0]   q_ff, q_in;
   logic [COORD_BITS-1:0] den_ff, den_in;
   logic [COORD_BITS-1:0] quo_ff, quo_in;
   logic [RW-1:0]   trial;
   logic            bit_in;
   logic [NB:0]     qr;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      bit_in = (cnt_ff == CW'(NB - 1 - 2 * FRAC_BITS));
      trial = {rem_ff[RW-2:0], bit_in};
      qr = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         q_in = '0;
         den_in = den;
      end else if (busy_ff) begin
         if (cnt_ff == CW'(NB)) begin
            qr = {1'b0, q_ff} + ((rem_ff >= (RW'(den_ff) - rem_ff)) ? 1'b1 : 1'b0);
            quo_in = (qr > (NB+1)'(VMAX)) ? VMAX : COORD_BITS'(qr);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (trial >= RW'(den_ff)) begin
               rem_in = trial - RW'(den_ff);
               q_in = {q_ff[NB-2:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in = {q_ff[NB-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo = quo_ff;

   `ASSERT_IMPL(a_rem_below_den, clock, reset, busy_ff |-> rem_ff < RW'(den_ff), "remainder out of range")
   `ASSERT_IMPL(a_done_ends_busy, clock, reset, done_ff |-> !busy_ff, "done while busy")
   `ASSERT_IMPL(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff), "done without run")
endmodule
`default_nettype wire

// ===== rtl/undistort_point_radial_tangential.sv =====
// ----------------------------------------------------------------------------
// Radial-tangential point undistortion
// Iterative inverse of the Brown-Conrady lens model, one point at a time.
// ----------------------------------------------------------------------------
// Usage: write coefficients, tolerance and pass limit over the csr_ channel
// while idle. Present a distorted point on req_; req_stall is high while a
// point is in work or a response is held by rsp_stall. One response per
// request appears on rsp_ with the estimate, outcome and passes used, and is
// held while rsp_stall is high; the next request is taken once the response
// register is free to reload. Each pass runs 26 operations through one shared
// multiply/add unit and one bit-serial reciprocal, for at most 255 passes.
// Reset clears the registers to their defaults and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module undistort_point_radial_tangential #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 27
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire signed [COORD_BITS-1:0]  req_in_x,
   input  wire signed [COORD_BITS-1:0]  req_in_y,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic [1:0]                   rsp_outcome,
   output logic [7:0]                   rsp_passes_used,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [upr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire  [31:0]                  csr_data
);
   `include "assert_macros.svh"
   localparam int CB = COORD_BITS;
   localparam logic signed [CB-1:0] ONE = CB'(1) << FRAC_BITS;
   localparam logic signed [CB-1:0] VMAX = {1'b0, {(CB-1){1'b1}}};
   // register file slots
   localparam int R_X0 = 0, R_Y0 = 1, R_X = 2, R_Y = 3, R_XX = 4, R_YY = 5,
      R_XY = 6, R_R2 = 7, R_T = 8, R_U = 9, R_DX = 10, R_DY = 11, R_ICD = 12,
      R_XN = 13, R_YN = 14, R_K1 = 15, R_K2 = 16, R_K3 = 17, R_P1 = 18,
      R_P2 = 19, R_ONE = 20;

   logic signed [CB-1:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   logic [upr_pkg::TOL_BITS-1:0] tol_ff;
   logic [upr_pkg::LIM_BITS-1:0] lim_ff;
   logic signed [CB-1:0] rf_ff [0:14];
   logic signed [CB-1:0] rf_in [0:14];
   upr_pkg::state_type st_ff, st_in;
   logic [4:0] step_ff, step_in;
   logic [7:0] pass_ff, pass_in;
   logic       rv_ff, rv_in;
   logic signed [CB-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [1:0] oc_ff, oc_in;
   logic [7:0] op_ff, op_in;
   logic       alu_start, rc_start, alu_done, rc_done;
   upr_pkg::alu_op_type alu_op;
   logic signed [CB-1:0] alu_a, alu_b, alu_res, rc_q;
   logic [4:0] sa, sb, sd;
   upr_pkg::alu_op_type sop;
   logic [CB-1:0] dxa, dya;

   function automatic logic signed [CB-1:0] pick(input logic [4:0] s,
      input logic signed [CB-1:0] v [0:14], input logic signed [CB-1:0] k1,
      input logic signed [CB-1:0] k2, input logic signed [CB-1:0] k3,
      input logic signed [CB-1:0] p1, input logic signed [CB-1:0] p2);
      logic signed [CB-1:0] r;
      case (s)
         5'(R_K1): r = k1;
         5'(R_K2): r = k2;
         5'(R_K3): r = k3;
         5'(R_P1): r = p1;
         5'(R_P2): r = p2;
         5'(R_ONE): r = ONE;
         default: r = (s < 5'd15) ? v[s[3:0]] : '0;
      endcase
      return r;
   endfunction

   // operation script of one pass: dest, a, b, op
   always_comb begin
      sop = upr_pkg::ALU_MUL;
      sa = 5'(R_X); sb = 5'(R_X); sd = 5'(R_XX);
      case (step_ff)
         5'd0:  begin sa = 5'(R_X);  sb = 5'(R_X);  sd = 5'(R_XX); end
         5'd1:  begin sa = 5'(R_Y);  sb = 5'(R_Y);  sd = 5'(R_YY); end
         5'd2:  begin sa = 5'(R_X);  sb = 5'(R_Y);  sd = 5'(R_XY); end
         5'd3:  begin sop = upr_pkg::ALU_ADD; sa = 5'(R_XX); sb = 5'(R_YY); sd = 5'(R_R2); end
         5'd4:  begin sa = 5'(R_K3); sb = 5'(R_R2); sd = 5'(R_T); end
         5'd5:  begin sop = upr_pkg::ALU_ADD; sa = 5'(R_T); sb = 5'(R_K2); sd = 5'(R_T); end
         5'd6:  begin sa = 5'(R_T);  sb = 5'(R_R2); sd = 5'(R_T); end
         5'd7:  begin sop = upr_pkg::ALU_ADD; sa = 5'(R_T); sb = 5'(R_K1); sd = 5'(R_T); end
         5'd8:  begin sa = 5'(R_T);  sb = 5'(R_R2); sd = 5'(R_T); end
         5'd9:  begin sop = upr_pkg::ALU_ADD; sa = 5'(R_ONE); sb = 5'(R_T); sd = 5'(R_ICD); end
         // ICD holds the denominator here; checked and inverted next
         5'd10: begin sa = 5'(R_P1); sb = 5'(R_XY); sd = 5'(R_T); end
         5'd11: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_T); sb = 5'(R_T); sd = 5'(R_DX); end
         5'd12: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_XX); sb = 5'(R_XX); sd = 5'(R_U); end
         5'd13: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_R2); sb = 5'(R_U); sd = 5'(R_U); end
         5'd14: begin sa = 5'(R_P2); sb = 5'(R_U); sd = 5'(R_U); end
         5'd15: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_DX); sb = 5'(R_U); sd = 5'(R_DX); end
         5'd16: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_YY); sb = 5'(R_YY); sd = 5'(R_U); end
         5'd17: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_R2); sb = 5'(R_U); sd = 5'(R_U); end
         5'd18: begin sa = 5'(R_P1); sb = 5'(R_U); sd = 5'(R_DY); end
         5'd19: begin sa = 5'(R_P2); sb = 5'(R_XY); sd = 5'(R_T); end
         5'd20: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_T); sb = 5'(R_T); sd = 5'(R_T); end
         5'd21: begin sop = upr_pkg::ALU_ADD; sa = 5'(R_DY); sb = 5'(R_T); sd = 5'(R_DY); end
         5'd22: begin sop = upr_pkg::ALU_SUB; sa = 5'(R_X0); sb = 5'(R_DX); sd = 5'(R_DX); end
         5'd23: begin sop = upr_pkg::ALU_SUB; sa = 5'(R_Y0); sb = 5'(R_DY); sd = 5'(R_DY); end
         5'd24: begin sa = 5'(R_DX); sb = 5'(R_ICD); sd = 5'(R_XN); end
         5'd25: begin sa = 5'(R_DY); sb = 5'(R_ICD); sd = 5'(R_YN); end
         default: begin sa = 5'(R_X); sb = 5'(R_X); sd = 5'(R_XX); end
      endcase
   end

   assign alu_op = sop;
   assign alu_a = pick(sa, rf_ff, k1_ff, k2_ff, k3_ff, p1_ff, p2_ff);
   assign alu_b = pick(sb, rf_ff, k1_ff, k2_ff, k3_ff, p1_ff, p2_ff);

   upr_alu #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .op(alu_op),
      .a(alu_a), .b(alu_b), .done(alu_done), .res(alu_res));

   upr_recip #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_recip (
      .clock(clock), .reset(reset), .start(rc_start), .den(CB'(rf_ff[R_ICD])),
      .done(rc_done), .quo(rc_q));

   assign dxa = (rf_ff[R_X] >= rf_ff[R_XN]) ? CB'(rf_ff[R_X] - rf_ff[R_XN])
                                            : CB'(rf_ff[R_XN] - rf_ff[R_X]);
   assign dya = (rf_ff[R_Y] >= rf_ff[R_YN]) ? CB'(rf_ff[R_Y] - rf_ff[R_YN])
                                            : CB'(rf_ff[R_YN] - rf_ff[R_Y]);

   always_comb begin
      st_in = st_ff;
      step_in = step_ff;
      pass_in = pass_ff;
      rf_in = rf_ff;
      alu_start = 1'b0;
      rc_start = 1'b0;
      rv_in = rv_ff && rsp_stall;
      ox_in = ox_ff; oy_in = oy_ff; oc_in = oc_ff; op_in = op_ff;
      case (st_ff)
         upr_pkg::ST_IDLE: begin
            if (req_valid && !(rv_ff && rsp_stall)) begin
               rf_in[R_X0] = req_in_x; rf_in[R_Y0] = req_in_y;
               rf_in[R_X] = req_in_x;  rf_in[R_Y] = req_in_y;
               pass_in = '0;
               st_in = upr_pkg::ST_CHECK;
            end
         end
         upr_pkg::ST_CHECK: begin
            step_in = '0;
            if (pass_ff == lim_ff) begin
               ox_in = rf_ff[R_X0]; oy_in = rf_ff[R_Y0];
               oc_in = upr_pkg::OUT_LIMIT; op_in = lim_ff;
               st_in = upr_pkg::ST_DONE;
            end else begin
               st_in = upr_pkg::ST_OP;
            end
         end
         upr_pkg::ST_OP: begin
            alu_start = 1'b1;
            st_in = upr_pkg::ST_OPWAIT;
         end
         upr_pkg::ST_OPWAIT: begin
            if (alu_done) begin
               rf_in[sd[3:0]] = alu_res;
               step_in = step_ff + 1'b1;
               if (step_ff == 5'd9)
                  st_in = upr_pkg::ST_RECIP;
               else if (step_ff == 5'd25)
                  st_in = upr_pkg::ST_DECIDE;
               else
                  st_in = upr_pkg::ST_OP;
            end
         end
         upr_pkg::ST_RECIP: begin
            if (rf_ff[R_ICD][CB-1]) begin
               ox_in = rf_ff[R_X]; oy_in = rf_ff[R_Y];
               oc_in = upr_pkg::OUT_NEG_SCALE; op_in = pass_ff + 1'b1;
               st_in = upr_pkg::ST_DONE;
            end else if (rf_ff[R_ICD] == '0) begin
               rf_in[R_ICD] = VMAX;
               st_in = upr_pkg::ST_OP;
            end else begin
               rc_start = 1'b1;
               st_in = upr_pkg::ST_RECIPWAIT;
            end
         end
         upr_pkg::ST_RECIPWAIT: begin
            if (rc_done) begin
               rf_in[R_ICD] = rc_q;
               st_in = upr_pkg::ST_OP;
            end
         end
         upr_pkg::ST_DECIDE: begin
            pass_in = pass_ff + 1'b1;
            if (dxa < CB'(tol_ff) && dya < CB'(tol_ff)) begin
               ox_in = rf_ff[R_X]; oy_in = rf_ff[R_Y];
               oc_in = upr_pkg::OUT_CONVERGED; op_in = pass_ff + 1'b1;
               st_in = upr_pkg::ST_DONE;
            end else begin
               rf_in[R_X] = rf_ff[R_XN]; rf_in[R_Y] = rf_ff[R_YN];
               st_in = upr_pkg::ST_CHECK;
            end
         end
         upr_pkg::ST_DONE: begin
            if (!(rv_ff && rsp_stall)) begin
               rv_in = 1'b1;
               st_in = upr_pkg::ST_IDLE;
            end
         end
         default: st_in = upr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= upr_pkg::ST_IDLE;
         rv_ff <= 1'b0;
         k1_ff <= '0; k2_ff <= '0; k3_ff <= '0; p1_ff <= '0; p2_ff <= '0;
         tol_ff <= 16'd13;
         lim_ff <= 8'd150;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         if (csr_valid) begin
            case (csr_index)
               upr_pkg::CSR_IDX_BITS'(upr_pkg::REG_K1): k1_ff <= CB'(signed'(csr_data));
               upr_pkg::CSR_IDX_BITS'(upr_pkg::REG_K2): k2_ff <= CB'(signed'(csr_data));
               upr_pkg::CSR_IDX_BITS'(upr_pkg::REG_K3): k3_ff <= CB'(signed'(csr_data));
               upr_pkg::CSR_IDX_BITS'(upr_pkg::REG_P1): p1_ff <= CB'(signed'(csr_data));
               upr_pkg::CSR_IDX_BITS'(upr_pkg::REG_P2): p2_ff <= CB'(signed'(csr_data));
               upr_pkg::CSR_IDX_BITS'(upr_pkg::REG_TOL): tol_ff <= csr_data[15:0];
               upr_pkg::CSR_IDX_BITS'(upr_pkg::REG_LIM): lim_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
      step_ff <= step_in;
      pass_ff <= pass_in;
      rf_ff <= rf_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oc_ff <= oc_in; op_ff <= op_in;
   end

   assign req_stall = (st_ff != upr_pkg::ST_IDLE) || (rv_ff && rsp_stall);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_outcome = oc_ff;
   assign rsp_passes_used = op_ff;

   `ASSERT_IMPL(a_rsp_hold, clock, reset, rv_ff && rsp_stall |=> rv_ff && $stable(ox_ff), "response changed under stall")
   `ASSERT_IMPL(a_pass_bound, clock, reset, st_ff != upr_pkg::ST_IDLE |-> pass_ff <= lim_ff, "pass count past limit")
   `ASSERT_IMPL(a_outcome_code, clock, reset, rv_ff |-> oc_ff != 2'd3, "bad outcome code")
endmodule
`default_nettype wire

// ===== sim/tb_undistort_point_radial_tangential.sv =====
// ----------------------------------------------------------------------------
// Undistortion testbench
// Drives distorted points through the radial-tangential undistortion block
// under several coefficient, tolerance and pass-limit settings, predicts every
// response with a fixed-point model of the iteration and compares field by
// field, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_undistort_point_radial_tangential;

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam longint ONE  = 64'sd1 << 27;
   localparam longint CYCLE_LIMIT = 64'd100_000_000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [1:0]         outcome;
      logic [7:0]         passes;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_in_x = '0;
   logic signed [31:0] req_in_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic [1:0] rsp_outcome;
   logic [7:0] rsp_passes_used;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [upr_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   // accepted_last marks that the request shown was taken at the last edge
   logic accepted_last = 1'b0;

   undistort_point_radial_tangential u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_x(req_in_x), .req_in_y(req_in_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_outcome(rsp_outcome), .rsp_passes_used(rsp_passes_used),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   longint coef_k1, coef_k2, coef_k3, coef_p1, coef_p2;
   longint tolerance, pass_limit;

   point_type    pending_points[$];
   estimate_type expected_estimates[$];
   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   int  mismatches = 0;
   int  responses_seen = 0;
   int  count_by_outcome[3] = '{0, 0, 0};
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint sat(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      logic [127:0] prod;
      logic [127:0] rounded;
      logic neg;
      logic [63:0] ma, mb;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      rounded = (prod + (128'd1 << 26)) >> 27;
      if (neg) begin
         if (rounded > 128'h8000_0000) return VMIN;
         return -longint'(rounded[63:0]);
      end
      if (rounded > 128'h7FFF_FFFF) return VMAX;
      return longint'(rounded[63:0]);
   endfunction

   function automatic longint qrecip(longint d);
      logic [127:0] q;
      logic [127:0] r;
      q = (128'd1 << 54) / d;
      r = (128'd1 << 54) % d;
      if (r >= d - r) q = q + 1;
      if (q > 128'h7FFF_FFFF) return VMAX;
      return longint'(q[63:0]);
   endfunction

   function automatic longint absdiff(longint a, longint b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic estimate_type undistort(point_type p);
      estimate_type e;
      longint x0, y0, x, y, xx, yy, xy, r2, poly, den, icd, dx, dy, xn, yn;
      x0 = p.x;
      y0 = p.y;
      x = x0;
      y = y0;
      e.x = p.x;
      e.y = p.y;
      e.outcome = upr_pkg::OUT_LIMIT;
      e.passes = pass_limit[7:0];
      for (int j = 0; j < pass_limit; j++) begin
         xx = qmul(x, x);
         yy = qmul(y, y);
         xy = qmul(x, y);
         r2 = sat(xx + yy);
         poly = sat(qmul(coef_k3, r2) + coef_k2);
         poly = sat(qmul(poly, r2) + coef_k1);
         poly = qmul(poly, r2);
         den = sat(ONE + poly);
         if (den < 0) begin
            e.x = 32'(x); e.y = 32'(y);
            e.outcome = upr_pkg::OUT_NEG_SCALE; e.passes = 8'(j + 1);
            return e;
         end
         icd = (den == 0) ? VMAX : qrecip(den);
         dx = sat(sat(qmul(coef_p1, xy) + qmul(coef_p1, xy))
                  + qmul(coef_p2, sat(r2 + sat(xx + xx))));
         dy = sat(qmul(coef_p1, sat(r2 + sat(yy + yy)))
                  + sat(qmul(coef_p2, xy) + qmul(coef_p2, xy)));
         xn = qmul(sat(x0 - dx), icd);
         yn = qmul(sat(y0 - dy), icd);
         if (absdiff(x, xn) < tolerance && absdiff(y, yn) < tolerance) begin
            e.x = 32'(x); e.y = 32'(y);
            e.outcome = upr_pkg::OUT_CONVERGED; e.passes = 8'(j + 1);
            return e;
         end
         x = xn;
         y = yn;
      end
      return e;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      accepted_last <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_estimates.push_back(undistort('{x: req_in_x, y: req_in_y}));
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || accepted_last)) begin
         if (pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_in_x <= pending_points[0].x;
            req_in_y <= pending_points[0].y;
            void'(pending_points.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      estimate_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (expected_estimates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response x=%0d y=%0d", rsp_out_x, rsp_out_y);
         end else begin
            want = expected_estimates.pop_front();
            if (want.outcome <= upr_pkg::OUT_LIMIT) count_by_outcome[want.outcome]++;
            if (rsp_out_x !== want.x || rsp_out_y !== want.y
                  || rsp_outcome !== want.outcome || rsp_passes_used !== want.passes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected x=%0d y=%0d outcome=%0d passes=%0d,",
                            " got x=%0d y=%0d outcome=%0d passes=%0d"},
                     want.x, want.y, want.outcome, want.passes,
                     rsp_out_x, rsp_out_y, rsp_outcome, rsp_passes_used);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_reg(input int idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx[upr_pkg::CSR_IDX_BITS-1:0];
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         upr_pkg::REG_K1:  coef_k1 = longint'(signed'(value));
         upr_pkg::REG_K2:  coef_k2 = longint'(signed'(value));
         upr_pkg::REG_K3:  coef_k3 = longint'(signed'(value));
         upr_pkg::REG_P1:  coef_p1 = longint'(signed'(value));
         upr_pkg::REG_P2:  coef_p2 = longint'(signed'(value));
         upr_pkg::REG_TOL: tolerance = value[15:0];
         upr_pkg::REG_LIM: pass_limit = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_points.size() > 0 || req_valid || expected_estimates.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic setup(input logic [31:0] k1, k2, k3, p1, p2,
                        input logic [15:0] tol, input logic [7:0] lim);
      drain();
      write_reg(upr_pkg::REG_K1, k1);
      write_reg(upr_pkg::REG_K2, k2);
      write_reg(upr_pkg::REG_K3, k3);
      write_reg(upr_pkg::REG_P1, p1);
      write_reg(upr_pkg::REG_P2, p2);
      write_reg(upr_pkg::REG_TOL, {16'd0, tol});
      write_reg(upr_pkg::REG_LIM, {24'd0, lim});
   endtask

   function automatic logic [31:0] small_coef();
      return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
   endfunction

   function automatic point_type random_point();
      point_type p;
      case ($urandom_range(9))
         0: begin p.x = $urandom; p.y = $urandom; end
         default: begin
            p.x = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            p.y = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
         end
      endcase
      return p;
   endfunction

   initial begin
      coef_k1 = 0; coef_k2 = 0; coef_k3 = 0; coef_p1 = 0; coef_p2 = 0;
      tolerance = 13; pass_limit = 150;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults, then a mild lens
      sender_idle_pct = 24; receiver_idle_pct = 73;
      pending_points.push_back('{x: 0, y: 0});
      pending_points.push_back('{x: 32'h7FFF_FFFF, y: 32'h8000_0000});
      pending_points.push_back('{x: 32'h0800_0000, y: -32'sh0800_0000});
      setup(32'hFE00_0000, 32'h0080_0000, 32'hFFF0_0000, 32'h0001_0000, 32'hFFFF_0000,
            16'd13, 8'd150);
      pending_points.push_back('{x: 0, y: 0});
      pending_points.push_back('{x: 32'h7FFF_FFFF, y: 32'h7FFF_FFFF});
      pending_points.push_back('{x: 32'h8000_0000, y: 32'h8000_0000});
      pending_points.push_back('{x: 32'h0C00_0000, y: 32'h0400_0000});
      pending_points.push_back('{x: -32'sh0200_0000, y: 32'h0600_0000});
      pending_points.push_back('{x: 32'h0000_0001, y: 32'hFFFF_FFFF});
      // strong negative k1: negative scale
      setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            16'hFFFF, 8'd255);
      pending_points.push_back('{x: 32'h0800_0000, y: 32'h0800_0000});
      pending_points.push_back('{x: 32'h7FFF_FFFF, y: 32'h0});
      pending_points.push_back('{x: 0, y: 0});
      // denominator exactly zero: k1 = -1 at r2 = 1
      setup(32'hF800_0000, 0, 0, 0, 0, 16'd13, 8'd3);
      pending_points.push_back('{x: 32'h0800_0000, y: 0});
      // zero tolerance and a limit of one pass: limit reached
      setup(32'h0100_0000, 0, 32'h7FFF_FFFF, 32'h0010_0000, 32'h0010_0000, 16'd0, 8'd1);
      pending_points.push_back('{x: 32'h0400_0000, y: 32'h0300_0000});
      pending_points.push_back('{x: 32'hFFFF_FFFF, y: 32'h0000_0001});
      setup(0, 0, 0, 0, 0, 16'd0, 8'd0);
      pending_points.push_back('{x: 32'h1234_5678, y: 32'h8765_4321});

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 4) begin sender_idle_pct = 73; receiver_idle_pct = 24; end
         if (phase == 7) begin sender_idle_pct = 0; receiver_idle_pct = 0; end
         case (phase % 3)
            0: setup(small_coef(), small_coef(), small_coef(), small_coef() >>> 4,
                     small_coef() >>> 4, 16'($urandom_range(1, 200)),
                     8'($urandom_range(1, 40)));
            1: setup($urandom, $urandom, $urandom, $urandom, $urandom,
                     16'($urandom), 8'($urandom_range(1, 255)));
            default: setup(small_coef() >>> 2, small_coef() >>> 6, small_coef() >>> 8,
                     small_coef() >>> 6, small_coef() >>> 6, 16'($urandom_range(1, 30)),
                     8'($urandom_range(5, 60)));
         endcase
         for (int i = 0; i < 50; i++) pending_points.push_back(random_point());
      end
      drain();
      $display("covered %0d responses: %0d converged, %0d negative scale, %0d at limit",
         responses_seen, count_by_outcome[0], count_by_outcome[1], count_by_outcome[2]);
      $display("settings ranged over extreme coefficients, zero tolerance and limits 0 to 255");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
